FILE: hdl/ssp_pkg.sv
`timescale 1ns / 1ps
// Package for the stepper slot positioner: field widths, register indexes,
// request and status codes and the half-step coil pattern table.
// No dependencies.
package ssp_pkg;

  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned SPS_W   = 12;
  localparam int unsigned TPS_W   = 8;
  localparam int unsigned STEPS_W = 15;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SPS_W;

  localparam logic [SPS_W-1:0] SPS_RESET = 12'd341;
  localparam logic [TPS_W-1:0] TPS_RESET = 8'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_SLOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_STEP = 1'b1;

  // Request types.
  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_BAD_SLOT  = 2'd1;
  localparam logic [STS_W-1:0] STS_BUSY_REJ  = 2'd2;

  localparam logic [COIL_W-1:0] COILS_OFF = 4'b0000;

  // Half-step sequence, one entry per phase.
  localparam logic [COIL_W-1:0] HALF_STEP_PAT [8] = '{
    4'b0001, 4'b0011, 4'b0010, 4'b0110,
    4'b0100, 4'b1100, 4'b1000, 4'b1001
  };

endpackage

FILE: hdl/ssp_req_if.sv
`timescale 1ns / 1ps
// Request channel of the stepper slot positioner: valid/ready plus payload.
// Depends on ssp_pkg.
interface ssp_req_if;
  import ssp_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] target_slot;

  modport source (output valid, output req_type, output target_slot, input ready);
  modport sink   (input valid, input req_type, input target_slot, output ready);
endinterface

FILE: hdl/ssp_res_if.sv
`timescale 1ns / 1ps
// Result channel of the stepper slot positioner: valid/ready plus payload.
// Depends on ssp_pkg.
interface ssp_res_if;
  import ssp_pkg::*;

  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coils;
  logic              busy_res;
  logic [SLOT_W-1:0] position;
  logic [STS_W-1:0]  status;

  modport source (output valid, output coils, output busy_res, output position,
                  output status, input ready);
  modport sink   (input valid, input coils, input busy_res, input position,
                  input status, output ready);
endinterface

FILE: hdl/stepper_slot_positioner.sv
`timescale 1ns / 1ps
// Top level of the stepper slot positioner: half-step sequencer, move
// controller and two-entry result buffer. Depends on ssp_pkg, ssp_req_if, ssp_res_if.

// The block takes one request transaction per clock cycle while req.ready is high
// and returns one result transaction for each, registered at the acceptance edge.
// A move request starts the first half-step at once; each tick request advances
// the dwell counter and steps the coils when ticks_per_step ticks have passed.
// All state is updated at the acceptance edge by a short path (one 3x12 multiply
// for the step count), so the rate is set only by the result side: a two-entry
// output buffer keeps the request side open while only the output entry is held,
// and the request side closes only while both entries hold untaken results.
// Configuration writes are taken on any cycle with cfg_we_i high.
module stepper_slot_positioner #(
  parameter int unsigned NUM_SLOTS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  ssp_req_if.sink                           req,
  ssp_res_if.source                         res
);
  import ssp_pkg::*;

  localparam int unsigned HALF   = NUM_SLOTS / 2;
  localparam int unsigned DIST_W = $clog2(HALF + 1);
  localparam int unsigned PROD_W = DIST_W + SPS_W;
  localparam logic signed [SLOT_W:0] HALF_S  = (SLOT_W+1)'(HALF);
  localparam logic signed [SLOT_W:0] SLOTS_S = (SLOT_W+1)'(NUM_SLOTS);
  localparam logic [SLOT_W-1:0]      SLOTS_U = SLOT_W'(NUM_SLOTS);

  // Configuration registers.
  logic [SPS_W-1:0] sps_q;
  logic [TPS_W-1:0] tps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q <= SPS_RESET;
      tps_q <= TPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEPS_PER_SLOT: sps_q <= cfg_wdata_i;
        REG_TICKS_PER_STEP: tps_q <= cfg_wdata_i[TPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  logic [PHASE_W-1:0] phase_q,   phase_d;
  logic [SLOT_W-1:0]  pos_q,     pos_d;
  logic [SLOT_W-1:0]  pend_q,    pend_d;
  logic               cw_q,      cw_d;
  logic [STEPS_W-1:0] steps_q,   steps_d;
  logic [TPS_W-1:0]   dwell_q,   dwell_d;
  logic [COIL_W-1:0]  coil_q,    coil_d;
  logic               moving_q,  moving_d;
  logic [STS_W-1:0]   sts;

  // Result buffer.
  logic              out_vld_q, skid_vld_q;
  logic [COIL_W-1:0] out_coils_q, skid_coils_q;
  logic              out_busy_q,  skid_busy_q;
  logic [SLOT_W-1:0] out_pos_q,   skid_pos_q;
  logic [STS_W-1:0]  out_sts_q,   skid_sts_q;

  logic in_acc, out_take;

  assign req.ready = !skid_vld_q;
  assign in_acc    = req.valid && req.ready;
  assign out_take  = out_vld_q && res.ready;

  // Shortest wrapped distance to the target slot.
  logic signed [SLOT_W:0] diff_raw, diff_adj, diff_abs;
  logic [DIST_W-1:0]      dist_slots;
  logic [PROD_W-1:0]      prod;
  logic [STEPS_W-1:0]     total;
  logic [TPS_W-1:0]       dwell_inc;
  logic [STEPS_W-1:0]     steps_dec;

  always_comb begin
    diff_raw = $signed({1'b0, req.target_slot}) - $signed({1'b0, pos_q});
    diff_adj = diff_raw;
    if (diff_raw > HALF_S) begin
      diff_adj = diff_raw - SLOTS_S;
    end else if (diff_raw < -HALF_S) begin
      diff_adj = diff_raw + SLOTS_S;
    end
    diff_abs   = (diff_adj < 0) ? -diff_adj : diff_adj;
    dist_slots = diff_abs[DIST_W-1:0];
    prod       = PROD_W'(dist_slots) * PROD_W'(sps_q);
    total      = STEPS_W'(prod);
  end

  assign dwell_inc = dwell_q + 1'b1;
  assign steps_dec = steps_q - 1'b1;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    cw_d     = cw_q;
    steps_d  = steps_q;
    dwell_d  = dwell_q;
    coil_d   = coil_q;
    moving_d = moving_q;
    sts      = STS_OK;
    if (req.req_type == REQ_MOVE) begin
      if (req.target_slot >= SLOTS_U) begin
        sts = STS_BAD_SLOT;
      end else if (moving_q) begin
        sts = STS_BUSY_REJ;
      end else if (total == '0) begin
        coil_d = COILS_OFF;
        pos_d  = req.target_slot;
      end else begin
        cw_d     = (diff_adj > 0);
        pend_d   = req.target_slot;
        steps_d  = total;
        dwell_d  = '0;
        moving_d = 1'b1;
        phase_d  = (diff_adj > 0) ? phase_q + 1'b1 : phase_q - 1'b1;
        coil_d   = HALF_STEP_PAT[phase_d];
      end
    end else if (moving_q) begin
      dwell_d = dwell_inc;
      if (dwell_inc >= tps_q) begin
        dwell_d = '0;
        steps_d = steps_dec;
        if (steps_dec != '0) begin
          phase_d = cw_q ? phase_q + 1'b1 : phase_q - 1'b1;
          coil_d  = HALF_STEP_PAT[phase_d];
        end else begin
          coil_d   = COILS_OFF;
          pos_d    = pend_q;
          moving_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      pos_q    <= '0;
      pend_q   <= '0;
      cw_q     <= 1'b0;
      steps_q  <= '0;
      dwell_q  <= '0;
      coil_q   <= COILS_OFF;
      moving_q <= 1'b0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      pend_q   <= pend_d;
      cw_q     <= cw_d;
      steps_q  <= steps_d;
      dwell_q  <= dwell_d;
      coil_q   <= coil_d;
      moving_q <= moving_d;
    end
  end

  // The skid entry fills only when a result arrives while the output entry
  // is held, and drains into the output entry when that one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_vld_q && !out_take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_coils_q <= skid_coils_q;
        out_busy_q  <= skid_busy_q;
        out_pos_q   <= skid_pos_q;
        out_sts_q   <= skid_sts_q;
      end
    end else if (in_acc) begin
      if (out_vld_q && !out_take) begin
        skid_coils_q <= coil_d;
        skid_busy_q  <= moving_d;
        skid_pos_q   <= pos_d;
        skid_sts_q   <= sts;
      end else begin
        out_coils_q <= coil_d;
        out_busy_q  <= moving_d;
        out_pos_q   <= pos_d;
        out_sts_q   <= sts;
      end
    end
  end

  assign res.valid    = out_vld_q;
  assign res.coils    = out_coils_q;
  assign res.busy_res = out_busy_q;
  assign res.position = out_pos_q;
  assign res.status   = out_sts_q;

endmodule

FILE: sim/tb_stepper_slot_positioner.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stepper slot positioner: a directed script,
// then random move and tick traffic checked against a cycle-free carousel model.
// Depends on ssp_pkg, ssp_req_if, ssp_res_if and stepper_slot_positioner.
module tb_stepper_slot_positioner;
  import ssp_pkg::*;

  localparam int SLOTS = 12;
  localparam int NROWS = 28;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              busy;
    logic [SLOT_W-1:0] position;
    logic [STS_W-1:0]  status;
  } coil_report_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              req_type;
    logic [SLOT_W-1:0] slot;
    logic [SPS_W-1:0]  sps;
    logic [TPS_W-1:0]  tps;
    logic              typed;
    logic [COIL_W-1:0] coils;
    logic              busy;
    logic [SLOT_W-1:0] position;
    logic [STS_W-1:0]  status;
  } script_row_t;

  // Columns: kind, request, slot, steps/slot, ticks/step, typed, coils, busy,
  // position, status. Rows with typed low are checked against the model only.
  localparam script_row_t SCRIPT [NROWS] = '{
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd12, 12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd0,  STS_BAD_SLOT},
    '{ROW_REQ, REQ_MOVE, 4'd15, 12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd0,  STS_BAD_SLOT},
    '{ROW_REQ, REQ_MOVE, 4'd0,  12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_CFG, REQ_TICK, 4'd0,  12'd1, 8'd1, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd1,  12'd0, 8'd0, 1'b1, 4'b0011,   1'b1, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd5,  12'd0, 8'd0, 1'b1, 4'b0011,   1'b1, 4'd0,  STS_BUSY_REJ},
    '{ROW_REQ, REQ_MOVE, 4'd14, 12'd0, 8'd0, 1'b1, 4'b0011,   1'b1, 4'd0,  STS_BAD_SLOT},
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd1,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd7,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd3,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd9,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd15, 12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd6,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd7,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd6,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd6,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd5,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd5,  STS_OK},
    '{ROW_CFG, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd11, 12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd11, STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_CFG, REQ_TICK, 4'd0,  12'd1, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd0,  12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_MOVE, 4'd11, 12'd0, 8'd0, 1'b0, COILS_OFF, 1'b0, 4'd0,  STS_OK},
    '{ROW_REQ, REQ_TICK, 4'd0,  12'd0, 8'd0, 1'b1, COILS_OFF, 1'b0, 4'd11, STS_OK}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ssp_req_if req_ch ();
  ssp_res_if res_ch ();

  stepper_slot_positioner #(
    .NUM_SLOTS(SLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch),
    .res        (res_ch)
  );

  // Carousel model state and its copy of the registers.
  logic [SPS_W-1:0]   slot_steps;
  logic [TPS_W-1:0]   step_ticks;
  logic [PHASE_W-1:0] ph_idx;
  logic [SLOT_W-1:0]  at_slot;
  logic [SLOT_W-1:0]  goal_slot;
  logic               go_cw;
  logic [STEPS_W-1:0] steps_todo;
  logic [TPS_W-1:0]   dwell;
  logic [COIL_W-1:0]  coil_q;
  logic               turning;

  coil_report_t expected_reports [$];
  int unsigned  mismatch_count;
  bit           idle_en;
  bit           hold_pending;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void take_half_step();
    ph_idx = go_cw ? ph_idx + 1'b1 : ph_idx - 1'b1;
    coil_q = HALF_STEP_PAT[ph_idx];
  endfunction

  function automatic coil_report_t advance_carousel(logic rt, logic [SLOT_W-1:0] slot);
    int                 diff;
    int                 dist_slots;
    logic [STEPS_W-1:0] total;
    logic [STS_W-1:0]   sts;
    sts = STS_OK;
    if (rt == REQ_MOVE) begin
      if (slot >= SLOTS) begin
        sts = STS_BAD_SLOT;
      end else if (turning) begin
        sts = STS_BUSY_REJ;
      end else begin
        // Shortest way round; an exact half turn keeps the sign of the difference.
        diff = int'(slot) - int'(at_slot);
        if (diff > SLOTS / 2) diff -= SLOTS;
        if (diff < -(SLOTS / 2)) diff += SLOTS;
        dist_slots = (diff < 0) ? -diff : diff;
        total = STEPS_W'(dist_slots * int'(slot_steps));
        if (total == '0) begin
          coil_q = COILS_OFF;
          at_slot = slot;
        end else begin
          go_cw = (diff > 0);
          goal_slot = slot;
          steps_todo = total;
          dwell = '0;
          turning = 1'b1;
          take_half_step();
        end
      end
    end else if (turning) begin
      dwell = dwell + 1'b1;
      if (dwell >= step_ticks) begin
        dwell = '0;
        steps_todo = steps_todo - 1'b1;
        if (steps_todo != '0) begin
          take_half_step();
        end else begin
          coil_q = COILS_OFF;
          at_slot = goal_slot;
          turning = 1'b0;
        end
      end
    end
    return '{coils: coil_q, busy: turning, position: at_slot, status: sts};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic offer_request(input logic rt, input logic [SLOT_W-1:0] slot,
                               input logic typed, input coil_report_t want);
    int gap;
    coil_report_t predicted;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rt;
    req_ch.target_slot <= slot;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    predicted = advance_carousel(rt, slot);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [SPS_W-1:0] sps, input logic [TPS_W-1:0] tps);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_STEPS_PER_SLOT;
    cfg_wdata_i <= sps;
    @(negedge clk_i);
    cfg_idx_i   <= REG_TICKS_PER_STEP;
    cfg_wdata_i <= CFG_DATA_W'(tps);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    slot_steps = sps;
    step_ticks = tps;
  endtask

  // While a move runs the traffic is mostly ticks, so moves get to finish;
  // when idle it is mostly moves, a quarter of them to slots that do not exist.
  task automatic run_traffic(input int count, input bit to_rest);
    int k;
    logic rt;
    logic [SLOT_W-1:0] slot;
    k = 0;
    while (k < count || (to_rest && turning)) begin
      if ($urandom_range(0, 3) != 0) slot = $urandom_range(0, SLOTS - 1);
      else slot = $urandom_range(SLOTS, 15);
      if (turning) rt = ($urandom_range(0, 15) != 0) ? REQ_TICK : REQ_MOVE;
      else rt = ($urandom_range(0, 3) == 0) ? REQ_TICK : REQ_MOVE;
      offer_request(rt, slot, 1'b0, '0);
      k++;
    end
  endtask

  initial begin : result_sink
    int n;
    res_ch.ready = 1'b0;
    forever begin
      if (hold_pending) begin
        // Long hold-off: the output buffer fills and the request side stalls.
        hold_pending = 1'b0;
        @(negedge clk_i);
        res_ch.ready <= 1'b0;
        for (n = 0; n < 80; n++) @(negedge clk_i);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 17);
        @(negedge clk_i);
        res_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    coil_report_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_reports.pop_front();
        if (res_ch.coils !== want.coils)
          report_mismatch($sformatf("coils got %b, expected %b", res_ch.coils, want.coils));
        if (res_ch.busy_res !== want.busy)
          report_mismatch($sformatf("busy got %b, expected %b", res_ch.busy_res, want.busy));
        if (res_ch.position !== want.position)
          report_mismatch($sformatf("position got %0d, expected %0d",
                                    res_ch.position, want.position));
        if (res_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d, expected %0d",
                                    res_ch.status, want.status));
      end
    end
  end

  initial begin : stimulus
    script_row_t row;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_STEPS_PER_SLOT;
    cfg_wdata_i        = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_TICK;
    req_ch.target_slot = '0;
    idle_en            = 1'b1;
    hold_pending       = 1'b0;
    mismatch_count     = 0;
    slot_steps         = SPS_RESET;
    step_ticks         = TPS_RESET;
    ph_idx             = '0;
    at_slot            = '0;
    goal_slot          = '0;
    go_cw              = 1'b0;
    steps_todo         = '0;
    dwell              = '0;
    coil_q             = COILS_OFF;
    turning            = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NROWS; r++) begin
      row = SCRIPT[r];
      if (row.kind == ROW_CFG) begin
        drain_results();
        load_settings(row.sps, row.tps);
      end else begin
        offer_request(row.req_type, row.slot, row.typed,
                      '{coils: row.coils, busy: row.busy, position: row.position,
                        status: row.status});
      end
    end

    drain_results();
    load_settings(12'd1, 8'd1);
    run_traffic(60, 1'b0);
    hold_pending = 1'b1;
    run_traffic(150, 1'b0);

    drain_results();
    load_settings(12'd2, 8'd3);
    run_traffic(200, 1'b0);

    drain_results();
    load_settings(12'($urandom_range(1, 6)), 8'($urandom_range(1, 4)));
    run_traffic(250, 1'b0);

    // Long move: finish any move left over, then one slot at a large step count.
    drain_results();
    load_settings(12'd700, 8'd1);
    while (turning) offer_request(REQ_TICK, 4'($urandom_range(0, 15)), 1'b0, '0);
    offer_request(REQ_MOVE, 4'((int'(at_slot) + 1) % SLOTS), 1'b0, '0);
    run_traffic(0, 1'b1);

    drain_results();
    load_settings(12'd1, 8'd255);
    run_traffic(190, 1'b0);

    // A move may still be under way here; the new hold time applies at once.
    drain_results();
    idle_en = 1'b0;
    load_settings(12'd3, 8'd2);
    run_traffic(180, 1'b0);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
